### hw/rtl/landing_detector_top_assert.svh
// Assertion macros used by the landing detector controller.
`ifndef LANDING_DETECTOR_TOP_ASSERT_SVH
`define LANDING_DETECTOR_TOP_ASSERT_SVH

// Same-cycle implication.
`define LD_ASSERT_IMPLIES(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("landing detector assertion failed");

// Next-cycle implication.
`define LD_ASSERT_NEXT(label, clk, rst, ante, cons) \
   label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("landing detector assertion failed");

`endif

### hw/rtl/ld_pkg.sv
// Types and constants shared by the landing detector modules.
`timescale 1ns / 1ps

package ld_pkg;

   localparam int DIV_STEPS = 12;

   localparam logic        OP_RESET    = 1'b0;
   localparam logic        OP_EVALUATE = 1'b1;

   localparam logic [31:0] WARMUP_US      = 32'd1000000;
   localparam logic [12:0] THRUST_MARGIN  = 13'd40;
   localparam logic signed [15:0] VERT_LIMIT    = 16'sd25;
   localparam logic [15:0] HORIZ_LIMIT    = 16'd100;
   localparam logic signed [16:0] GROUND_MARGIN = 17'sd5;
   localparam logic [23:0] DISARM_SCALE   = 24'd1000;
   localparam logic [23:0] DELAY_US_RESET = 24'd1000000;

   typedef struct packed {
      logic capture;
      logic update;
      logic load;
      logic step;
      logic finish;
   } ld_cmd_type;

   typedef struct packed {
      logic warm;
      logic div_last;
   } ld_status_type;

endpackage

### hw/rtl/ld_ctrl.sv
// Sequencing state machine and result handshake of the landing detector.
`timescale 1ns / 1ps
`include "landing_detector_top_assert.svh"

module ld_ctrl (
   input  logic              clock,
   input  logic              reset,
   input  logic              req_tvalid,
   output logic              req_tready,
   output logic              rsp_tvalid,
   input  logic              rsp_tready,
   input  ld_pkg::ld_status_type status,
   output ld_pkg::ld_cmd_type    cmd
);
   import ld_pkg::*;

   typedef enum logic [4:0] {
      S_IDLE   = 5'b00001,
      S_UPDATE = 5'b00010,
      S_LOAD   = 5'b00100,
      S_DIVIDE = 5'b01000,
      S_DONE   = 5'b10000
   } ld_state_type;

   ld_state_type state_ff, state_in;
   logic         rsp_tvalid_ff, rsp_tvalid_in;
   logic         out_free;

   assign out_free   = !rsp_tvalid_ff || rsp_tready;
   assign req_tready = (state_ff == S_IDLE);
   assign rsp_tvalid = rsp_tvalid_ff;

   always_comb begin
      cmd      = '0;
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_tvalid) begin
               cmd.capture = 1'b1;
               state_in    = S_UPDATE;
            end
         end
         S_UPDATE: begin
            cmd.update = 1'b1;
            state_in   = status.warm ? S_LOAD : S_DONE;
         end
         S_LOAD: begin
            cmd.load = 1'b1;
            state_in = S_DIVIDE;
         end
         S_DIVIDE: begin
            cmd.step = 1'b1;
            if (status.div_last) begin
               state_in = S_DONE;
            end
         end
         S_DONE: begin
            if (out_free) begin
               cmd.finish = 1'b1;
               state_in   = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_comb begin
      priority if (cmd.finish) begin
         rsp_tvalid_in = 1'b1;
      end else if (rsp_tready) begin
         rsp_tvalid_in = 1'b0;
      end else begin
         rsp_tvalid_in = rsp_tvalid_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff      <= S_IDLE;
         rsp_tvalid_ff <= 1'b0;
      end else begin
         state_ff      <= state_in;
         rsp_tvalid_ff <= rsp_tvalid_in;
      end
   end

   `LD_ASSERT_NEXT(a_accept_starts, clock, reset, req_tvalid && req_tready, state_ff == S_UPDATE)
   `LD_ASSERT_NEXT(a_divide_ends, clock, reset, state_ff == S_DIVIDE && status.div_last, state_ff == S_DONE)
   `LD_ASSERT_NEXT(a_finish_valid, clock, reset, cmd.finish, rsp_tvalid_ff)
   `LD_ASSERT_NEXT(a_done_waits, clock, reset, state_ff == S_DONE && rsp_tvalid_ff && !rsp_tready, state_ff == S_DONE)

endmodule

### hw/rtl/ld_datapath.sv
// Datapath of the landing detector: state registers, serial divider, tests.
`timescale 1ns / 1ps

module ld_datapath (
   input  logic                  clock,
   input  logic                  reset,
   input  ld_pkg::ld_cmd_type    cmd,
   output ld_pkg::ld_status_type status,
   input  logic [111:0]          req_tdata,
   input  logic                  req_tuser,
   input  logic                  csr_wr_en,
   input  logic [13:0]           csr_wr_data,
   output logic                  landed,
   output logic                  possible_landing,
   output logic                  minimal_thrust
);
   import ld_pkg::*;

   // captured item
   logic               op_ff;
   logic [31:0]        time_ff;
   logic signed [15:0] vz_ff;
   logic [15:0]        vxy_ff;
   logic [11:0]        thr_ff;
   logic               trusted_ff;
   logic signed [15:0] height_ff;
   logic signed [15:0] floor_ff;

   // detector state
   logic [31:0] hold_ff;
   logic [31:0] start_ff;
   logic [43:0] sum_ff;
   logic [31:0] count_ff;
   logic [23:0] delay_us_ff;
   logic        warm_ff;

   // divider
   logic [31:0] rem_ff, rem_in;
   logic [11:0] quo_ff, quo_in;
   logic [3:0]  div_cnt_ff;
   logic [32:0] trial;
   logic        trial_ge;

   // results
   logic landed_ff, possible_ff, minimal_ff;

   logic [31:0]        start_eff;
   logic [31:0]        elapsed;
   logic               warm;
   logic               minimal;
   logic               speed_ok;
   logic               height_ok;
   logic               possible;
   logic               held;
   logic signed [16:0] height_ext;
   logic signed [16:0] floor_lim;

   assign start_eff = (start_ff == '0) ? time_ff : start_ff;
   assign elapsed   = time_ff - start_eff;
   assign warm      = (op_ff == OP_EVALUATE) && (elapsed > WARMUP_US);

   assign status.warm     = warm;
   assign status.div_last = (div_cnt_ff == 4'(DIV_STEPS - 1));

   assign trial    = {rem_ff, quo_ff[11]};
   assign trial_ge = (trial >= {1'b0, count_ff});
   assign rem_in   = trial_ge ? 32'(trial - {1'b0, count_ff}) : trial[31:0];
   assign quo_in   = {quo_ff[10:0], trial_ge};

   assign minimal    = warm_ff && (({1'b0, thr_ff} + THRUST_MARGIN) < {1'b0, quo_ff});
   assign speed_ok   = (vz_ff <= VERT_LIMIT) && (vz_ff >= -VERT_LIMIT)
                       && (vxy_ff <= HORIZ_LIMIT);
   assign height_ext = {height_ff[15], height_ff};
   assign floor_lim  = {floor_ff[15], floor_ff} + GROUND_MARGIN;
   assign height_ok  = !trusted_ff || floor_ff[15] || (height_ext <= floor_lim);
   assign possible   = minimal && speed_ok && height_ok;
   assign held       = (time_ff - hold_ff) > {8'd0, delay_us_ff};

   // item capture and divider registers, no reset needed
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         op_ff      <= req_tuser;
         time_ff    <= req_tdata[31:0];
         vz_ff      <= req_tdata[47:32];
         vxy_ff     <= req_tdata[63:48];
         thr_ff     <= req_tdata[75:64];
         trusted_ff <= req_tdata[76];
         height_ff  <= req_tdata[92:77];
         floor_ff   <= req_tdata[108:93];
      end
      if (cmd.load) begin
         rem_ff     <= sum_ff[43:12];
         quo_ff     <= sum_ff[11:0];
         div_cnt_ff <= '0;
      end else if (cmd.step) begin
         rem_ff     <= rem_in;
         quo_ff     <= quo_in;
         div_cnt_ff <= div_cnt_ff + 4'd1;
      end
      if (cmd.finish) begin
         landed_ff   <= possible && held;
         possible_ff <= possible;
         minimal_ff  <= minimal;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         hold_ff     <= '0;
         start_ff    <= '0;
         sum_ff      <= '0;
         count_ff    <= '0;
         warm_ff     <= 1'b0;
         delay_us_ff <= DELAY_US_RESET;
      end else begin
         if (csr_wr_en) begin
            delay_us_ff <= 24'(csr_wr_data) * DISARM_SCALE;
         end
         if (cmd.update) begin
            warm_ff <= warm;
            if (op_ff == OP_RESET) begin
               start_ff <= '0;
               sum_ff   <= '0;
               count_ff <= '0;
            end else begin
               start_ff <= start_eff;
               if (warm && (count_ff != '1)) begin
                  count_ff <= count_ff + 32'd1;
                  sum_ff   <= sum_ff + {32'd0, thr_ff};
               end
            end
         end
         if (cmd.finish && !possible) begin
            hold_ff <= time_ff;
         end
      end
   end

   assign landed           = landed_ff;
   assign possible_landing = possible_ff;
   assign minimal_thrust   = minimal_ff;

endmodule

### hw/rtl/landing_detector_top.sv
// Top level of the landing detector: controller, datapath and stream ports.
`timescale 1ns / 1ps
// An evaluate item past warm-up walks update, divider load, 12 divider steps
// and result before rsp_tvalid rises; a reset item or one inside warm-up goes
// from update straight to the result. One item is worked at a time: a new item
// is taken only once the last result is in the result register. A 12-step
// restoring divider forms the throttle average. Synchronous active-high reset
// returns the disarm delay to 1000 ms and clears the detector state.

module landing_detector_top (
   input  logic         clock,
   input  logic         reset,
   // input item stream
   input  logic         req_tvalid,
   output logic         req_tready,
   // time_us[31:0], vertical_speed[47:32], horizontal_speed[63:48],
   // throttle[75:64], surface_trusted[76], surface_height[92:77],
   // surface_floor[108:93], zero fill [111:109]
   input  logic [111:0] req_tdata,
   // operation[0]: 0 reset, 1 evaluate
   input  logic         req_tuser,
   // result stream
   output logic         rsp_tvalid,
   input  logic         rsp_tready,
   // landed[0], possible_landing[1], minimal_thrust[2], zero fill [7:3]
   output logic [7:0]   rsp_tdata,
   // disarm delay register, write only
   input  logic         csr_wr_en,
   input  logic [13:0]  csr_wr_data
);
   import ld_pkg::*;

   ld_cmd_type    cmd;
   ld_status_type status;
   logic          landed;
   logic          possible_landing;
   logic          minimal_thrust;

   // Controller: takes an item only when idle, walks update, divide and
   // result steps, and holds the result register until the sink takes it.
   ld_ctrl u_ctrl (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .status     (status),
      .cmd        (cmd)
   );

   // Datapath: captures the item, keeps start mark, hold timer and throttle
   // sum and count, divides sum by count for the average, forms the flags.
   ld_datapath u_datapath (
      .clock            (clock),
      .reset            (reset),
      .cmd              (cmd),
      .status           (status),
      .req_tdata        (req_tdata),
      .req_tuser        (req_tuser),
      .csr_wr_en        (csr_wr_en),
      .csr_wr_data      (csr_wr_data),
      .landed           (landed),
      .possible_landing (possible_landing),
      .minimal_thrust   (minimal_thrust)
   );

   // Pack the result item, low bit first.
   assign rsp_tdata = {5'd0, minimal_thrust, possible_landing, landed};

endmodule

### test/landing_detector_top_tb.sv
// Self-checking stream testbench for the landing detector top level.
`timescale 1ns / 1ps

module landing_detector_top_tb;
   import ld_pkg::*;

   localparam int CLK_HALF_NS     = 6;
   localparam int RESET_CYCLES    = 6;
   localparam int IDLE_PCT        = 19;
   // Settling time after the last pending result has drained.
   localparam int TAIL_CYCLES     = 20;
   localparam int DRAIN_LIMIT     = 5000;
   localparam int HOLD_OFF_CYCLES = 300;
   localparam int CYCLE_LIMIT     = 400000;
   localparam int RANDOM_ITEMS    = 340;
   localparam int CHUNK_ITEMS     = 70;
   localparam int STEADY_ITEMS    = 120;
   localparam int MAX_REPORTS     = 10;
   localparam logic [13:0] DISARM_RESET_MS = 14'(DELAY_US_RESET / DISARM_SCALE);

   // One input item, with the fields at the widths of the block.
   typedef struct {
      logic               op;
      logic [31:0]        time_us;
      logic signed [15:0] vz;
      logic [15:0]        vxy;
      logic [11:0]        thr;
      logic               trusted;
      logic signed [15:0] height;
      logic signed [15:0] floor_cm;
   } sample_type;

   // Result flags in the bit order of rsp_tdata[2:0].
   typedef struct packed {
      logic minimal;
      logic possible;
      logic landed;
   } flags_type;

   logic          clock;
   logic          reset;
   logic          req_tvalid;
   logic          req_tready;
   // time_us, vertical_speed, horizontal_speed, throttle, surface_trusted,
   // surface_height, surface_floor, zero fill
   logic [111:0]  req_tdata;
   // operation
   logic          req_tuser;
   logic          rsp_tvalid;
   logic          rsp_tready;
   // landed, possible_landing, minimal_thrust, zero fill
   logic [7:0]    rsp_tdata;
   logic          csr_wr_en;
   logic [13:0]   csr_wr_data;

   // Detector state as the testbench sees it.
   logic [13:0]   delay_ms;
   logic [31:0]   hold_start_us;
   logic [31:0]   det_start_us;
   logic [43:0]   thr_sum;
   logic [31:0]   acc_count;

   flags_type     expected_flags_q[$];
   int            failures;
   int            cycle_count;
   logic          steady;          // high: neither side idles
   int            hold_off_seq;    // bump to make the receiver hold off
   int            hold_off_seen;
   int            stall_left;

   landing_detector_top u_dut (
      .clock       (clock),
      .reset       (reset),
      .req_tvalid  (req_tvalid),
      .req_tready  (req_tready),
      .req_tdata   (req_tdata),
      .req_tuser   (req_tuser),
      .rsp_tvalid  (rsp_tvalid),
      .rsp_tready  (rsp_tready),
      .rsp_tdata   (rsp_tdata),
      .csr_wr_en   (csr_wr_en),
      .csr_wr_data (csr_wr_data)
   );

   initial begin
      clock = 1'b0;
      forever #CLK_HALF_NS clock = ~clock;
   end

   // Log a failure; print only the first few, count the rest.
   task automatic report_mismatch(string what, int want, int got);
      failures++;
      if (failures <= MAX_REPORTS) begin
         $display("mismatch %s: expected %0d, got %0d at %0t", what, want, got, $realtime);
      end
   endtask

   // Advance the detector state by one item and return the flags it yields.
   function automatic flags_type predict_flags(sample_type s);
      flags_type   f;
      logic [31:0] age_us;
      logic [31:0] held_us;
      logic [31:0] limit_us;
      longint      avg_v;
      int          vabs;
      f = '0;
      if (s.op == OP_RESET) begin
         hold_start_us = s.time_us;
         det_start_us  = '0;
         thr_sum       = '0;
         acc_count     = '0;
         return f;
      end
      // A start mark of zero reads as not started, so time zero latches again.
      if (det_start_us == '0) det_start_us = s.time_us;
      age_us = s.time_us - det_start_us;
      if (age_us > WARMUP_US) begin
         // Hold the count and the sum once the counter is full.
         if (acc_count != '1) begin
            acc_count = acc_count + 32'd1;
            thr_sum   = thr_sum + 44'(s.thr);
         end
         avg_v = thr_sum / acc_count;
         f.minimal = longint'(s.thr) < avg_v - longint'(THRUST_MARGIN);
      end
      vabs = (s.vz < 0) ? -int'(s.vz) : int'(s.vz);
      f.possible = f.minimal && (vabs <= VERT_LIMIT) && (s.vxy <= HORIZ_LIMIT);
      // Skip the height test with an untrusted sensor or an unknown floor.
      if (s.trusted && s.floor_cm >= 0) begin
         f.possible = f.possible && (int'(s.height) <= int'(s.floor_cm) + GROUND_MARGIN);
      end
      if (!f.possible) begin
         hold_start_us = s.time_us;
      end else begin
         held_us  = s.time_us - hold_start_us;
         limit_us = delay_ms * DISARM_SCALE;
         f.landed = held_us > limit_us;
      end
      return f;
   endfunction

   function automatic sample_type evt(logic op, logic [31:0] t, int vz, int vxy, int thr,
                                      logic trusted, int height, int floor_cm);
      sample_type s;
      s.op       = op;
      s.time_us  = t;
      s.vz       = 16'(vz);
      s.vxy      = 16'(vxy);
      s.thr      = 12'(thr);
      s.trusted  = trusted;
      s.height   = 16'(height);
      s.floor_cm = 16'(floor_cm);
      return s;
   endfunction

   // Offer one item; idle first at random, then hold it until accepted.
   // Leave tvalid high afterwards so back-to-back items never drop it.
   task automatic send_item(sample_type s);
      if (!steady) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_tvalid <= 1'b0;
            @(posedge clock);
         end
      end
      req_tvalid <= 1'b1;
      req_tuser  <= s.op;
      req_tdata  <= {3'b000, s.floor_cm, s.height, s.trusted, s.thr, s.vxy, s.vz, s.time_us};
      do @(posedge clock); while (!req_tready);
      expected_flags_q.push_back(predict_flags(s));
   endtask

   // Drop tvalid and wait for every pending result, then let the block settle.
   task automatic wait_idle();
      int waited;
      waited = 0;
      req_tvalid <= 1'b0;
      while (expected_flags_q.size() != 0 && waited < DRAIN_LIMIT) begin
         @(posedge clock);
         waited++;
      end
      repeat (TAIL_CYCLES) @(posedge clock);
   endtask

   // Write the disarm delay while nothing is in flight.
   task automatic set_disarm_delay(logic [13:0] value);
      wait_idle();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(posedge clock);
      delay_ms = value;
      csr_wr_en <= 1'b0;
   endtask

   // Time advance between samples: mostly control-loop scale, some large jumps.
   function automatic logic [31:0] next_step();
      int r;
      r = $urandom_range(99);
      if (r < 10) return $urandom_range(2000, 1);
      if (r < 55) return $urandom_range(700000, 100000);
      if (r < 92) return $urandom_range(4000000, 700000);
      return $urandom;
   endfunction

   // Fully random item, reset or evaluate, every bit free.
   function automatic sample_type noise_sample();
      sample_type s;
      s.op       = 1'($urandom_range(1));
      s.time_us  = $urandom;
      s.vz       = 16'($urandom);
      s.vxy      = 16'($urandom);
      s.thr      = 12'($urandom);
      s.trusted  = 1'($urandom_range(1));
      s.height   = 16'($urandom);
      s.floor_cm = 16'($urandom);
      return s;
   endfunction

   // Evaluate item shaped like a real approach: high throttle while climbing,
   // low throttle and small speeds near the ground once descending.
   function automatic sample_type flight_sample(logic [31:0] t, bit descending);
      sample_type s;
      int         r;
      s.op      = OP_EVALUATE;
      s.time_us = t;
      r = $urandom_range(99);
      if (r < 80)      s.vz = 16'(int'($urandom_range(50)) - 25);
      else if (r < 90) s.vz = $urandom_range(1) ? 16'sd26 : -16'sd26;
      else             s.vz = 16'($urandom);
      r = $urandom_range(99);
      if (r < 80)      s.vxy = 16'($urandom_range(100));
      else if (r < 90) s.vxy = 16'd101;
      else             s.vxy = 16'($urandom);
      if (!descending)                 s.thr = 12'($urandom_range(4095, 1200));
      else if ($urandom_range(99) < 90) s.thr = 12'($urandom_range(300));
      else                             s.thr = 12'($urandom);
      s.trusted = 1'($urandom_range(1));
      if ($urandom_range(99) < 20) s.floor_cm = 16'($urandom) | 16'h8000;
      else                         s.floor_cm = 16'($urandom_range(2000));
      if ($urandom_range(99) < 85) begin
         s.height = 16'(int'(s.floor_cm) + int'($urandom_range(12)) - 6);
      end else begin
         s.height = 16'($urandom);
      end
      return s;
   endfunction

   // One flight: a reset event, then a run of evaluates with random content,
   // broken up now and then by noise items.
   task automatic run_flight(ref int sent);
      logic [31:0] t;
      int          len;
      int          climb;
      int          r;
      sample_type  s;
      r = $urandom_range(99);
      if (r < 15)      t = 32'hFFFF_FFFF - $urandom_range(3000000);
      else if (r < 25) t = '0;
      else             t = $urandom;
      s = noise_sample();
      s.op      = OP_RESET;
      s.time_us = t;
      send_item(s);
      len   = $urandom_range(24, 6);
      climb = $urandom_range(5, 1);
      for (int k = 0; k < len; k++) begin
         t = t + next_step();
         if ($urandom_range(99) < 12) s = noise_sample();
         else                         s = flight_sample(t, k >= climb);
         send_item(s);
      end
      sent += len + 1;
   endtask

   // Start mark and warm-up: a first evaluate at time zero latches again,
   // and accumulation begins only past exactly one second.
   task automatic test_warmup_start();
      send_item(evt(OP_RESET, 32'd0, -32768, 65535, 4095, 1'b1, -32768, 32767));
      send_item(evt(OP_EVALUATE, 32'd0, 0, 0, 4095, 1'b0, 0, -1));
      send_item(evt(OP_EVALUATE, 32'd500000, 0, 0, 4095, 1'b0, 0, -1));
      send_item(evt(OP_EVALUATE, 32'd1500000, 0, 0, 4095, 1'b0, 0, -1));
      send_item(evt(OP_EVALUATE, 32'd1500001, 0, 0, 4095, 1'b0, 0, -1));
      wait_idle();
   endtask

   // Each landing condition at its limit and just past it, then landed.
   task automatic test_landing_conditions();
      send_item(evt(OP_EVALUATE, 32'd1600000, 25, 100, 0, 1'b1, 105, 100));
      send_item(evt(OP_EVALUATE, 32'd2600002, -25, 0, 0, 1'b1, 32767, -1));
      send_item(evt(OP_EVALUATE, 32'd2700000, 26, 0, 0, 1'b0, 0, -1));
      send_item(evt(OP_EVALUATE, 32'd2800000, -32768, 0, 0, 1'b0, 0, -1));
      send_item(evt(OP_EVALUATE, 32'd2900000, 0, 101, 0, 1'b0, 0, -1));
      send_item(evt(OP_EVALUATE, 32'd3000000, 0, 0, 0, 1'b1, 106, 100));
      // Floor at its top: the margin must not wrap at 16 bits.
      send_item(evt(OP_EVALUATE, 32'd3100000, 0, 0, 0, 1'b1, 32767, 32767));
      send_item(evt(OP_EVALUATE, 32'd3200000, 32767, 65535, 4095, 1'b0, 0, -1));
      wait_idle();
   endtask

   // An average under the margin never flags minimal thrust.
   task automatic test_low_average();
      send_item(evt(OP_RESET, 32'd4000000, 0, 0, 0, 1'b0, 0, -1));
      send_item(evt(OP_EVALUATE, 32'd4000000, 0, 0, 30, 1'b0, 0, -1));
      send_item(evt(OP_EVALUATE, 32'd5000001, 0, 0, 30, 1'b0, 0, -1));
      send_item(evt(OP_EVALUATE, 32'd5100000, 0, 0, 0, 1'b0, 0, -1));
      wait_idle();
   endtask

   // Warm-up and hold timing across the 32-bit time wrap; the untrusted
   // sensor skips the height test.
   task automatic test_time_wrap();
      send_item(evt(OP_RESET, 32'hFFF0_0000, 0, 0, 0, 1'b0, 0, -1));
      send_item(evt(OP_EVALUATE, 32'hFFF0_0000, 0, 0, 3000, 1'b0, 0, -1));
      send_item(evt(OP_EVALUATE, 32'h000F_4241, 0, 0, 3000, 1'b0, 0, -1));
      send_item(evt(OP_EVALUATE, 32'h0010_0000, 0, 0, 0, 1'b0, 30000, 100));
      send_item(evt(OP_EVALUATE, 32'h0020_0000, 0, 0, 0, 1'b0, 0, -1));
      wait_idle();
   endtask

   // Hold off the receiver while flights keep coming, so the block fills
   // and stalls its input.
   task automatic test_backpressure();
      int sent;
      sent = 0;
      hold_off_seq <= hold_off_seq + 1;
      while (sent < 30) run_flight(sent);
      wait_idle();
   endtask

   // Random flights in chunks, each under its own disarm delay: zero, 10000 and
   // the maximum first, then random settings. The opening stretch runs without idling.
   task automatic test_random_flights();
      int          sent;
      int          chunk;
      logic [13:0] setting;
      sent  = 0;
      chunk = 0;
      while (sent < RANDOM_ITEMS) begin
         if (sent >= chunk * CHUNK_ITEMS) begin
            case (chunk)
               0: begin
                  setting = '0;
               end
               1: begin
                  setting = 14'd10000;
               end
               2: begin
                  setting = '1;
               end
               default: begin
                  setting = 14'($urandom_range(3000));
               end
            endcase
            set_disarm_delay(setting);
            chunk++;
         end
         steady <= (sent < STEADY_ITEMS);
         run_flight(sent);
      end
      wait_idle();
   endtask

   // Receiver: check each accepted result against the oldest expectation,
   // then pick the next tready (long hold-off, random idle or steady).
   always @(posedge clock) begin : rsp_check
      flags_type got_flags;
      flags_type want_flags;
      if (!reset && rsp_tvalid && rsp_tready) begin
         got_flags = flags_type'(rsp_tdata[2:0]);
         if (expected_flags_q.size() == 0) begin
            report_mismatch("result with no item pending", 0, int'(rsp_tdata));
         end else begin
            want_flags = expected_flags_q.pop_front();
            if (got_flags.landed !== want_flags.landed) begin
               report_mismatch("landed", want_flags.landed, got_flags.landed);
            end
            if (got_flags.possible !== want_flags.possible) begin
               report_mismatch("possible_landing", want_flags.possible, got_flags.possible);
            end
            if (got_flags.minimal !== want_flags.minimal) begin
               report_mismatch("minimal_thrust", want_flags.minimal, got_flags.minimal);
            end
         end
      end
      if (hold_off_seq != hold_off_seen) begin
         hold_off_seen = hold_off_seq;
         stall_left    = HOLD_OFF_CYCLES;
      end
      if (reset) begin
         rsp_tready <= 1'b0;
      end else if (stall_left > 0) begin
         stall_left--;
         rsp_tready <= 1'b0;
      end else begin
         rsp_tready <= steady || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Watchdog: end a hung run.
   initial begin : watchdog
      cycle_count = 0;
      while (cycle_count <= CYCLE_LIMIT) begin
         @(posedge clock);
         cycle_count++;
      end
      $display("FAIL landing_detector_top");
      $finish;
   end

   initial begin
      // Drive every input to a known value from time zero.
      reset         <= 1'b1;
      req_tvalid    <= 1'b0;
      req_tuser     <= OP_RESET;
      req_tdata     <= '0;
      csr_wr_en     <= 1'b0;
      csr_wr_data   <= '0;
      steady        <= 1'b0;
      hold_off_seq  <= 0;
      hold_off_seen  = 0;
      stall_left     = 0;
      failures       = 0;
      // Mirror the post-reset state of the block.
      delay_ms       = DISARM_RESET_MS;
      hold_start_us  = '0;
      det_start_us   = '0;
      thr_sum        = '0;
      acc_count      = '0;
      repeat (RESET_CYCLES) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      // Directed part runs under the reset value of the disarm delay.
      test_warmup_start();
      test_landing_conditions();
      test_low_average();
      test_time_wrap();
      test_backpressure();
      test_random_flights();

      // Anything still pending after the drain is a missing result.
      if (expected_flags_q.size() != 0) begin
         report_mismatch("results never delivered", 0, expected_flags_q.size());
      end
      if (failures == 0) begin
         $display("PASS landing_detector_top");
      end else begin
         $display("FAIL landing_detector_top");
      end
      $finish;
   end

endmodule
